// ----- rtl/core/sclru_pkg.sv -----
package sclru_pkg;

  localparam int unsigned ENTRIES_DEF     = 64;
  localparam int unsigned SECTOR_BITS_DEF = 32;
  localparam int unsigned SECTOR_W        = 32;
  localparam int unsigned WAY_W           = 6;
  localparam int unsigned ACTION_W        = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_FL_SCAN,
    ST_FL_RD,
    ST_OUT
  } state_e;

  // commands to the recency rank line
  typedef struct packed {
    logic rotate;
    logic touch;
  } rank_cmd_t;

endpackage

// ----- rtl/core/sclru_if.sv -----
interface sclru_req_if import sclru_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, output action, output sector, input ready);
  modport sink (input valid, input action, input sector, output ready);
endinterface

interface sclru_rsp_if import sclru_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WAY_W-1:0]    way;
  logic                hit;
  logic                fill_needed;
  logic                writeback_needed;
  logic [SECTOR_W-1:0] writeback_sector;
  logic                last;

  modport source (
    output valid, output way, output hit, output fill_needed,
    output writeback_needed, output writeback_sector, output last, input ready
  );
  modport sink (
    input valid, input way, input hit, input fill_needed,
    input writeback_needed, input writeback_sector, input last, output ready
  );
endinterface

// ----- rtl/core/sclru_ram.sv -----
module sclru_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sclru_rank.sv -----
module sclru_rank import sclru_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rank_cmd_t                  cmd_i,
  input  logic [$clog2(ENTRIES)-1:0] idx_i,
  input  logic [$clog2(ENTRIES)-1:0] old_i,
  output logic [$clog2(ENTRIES)-1:0] head_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [IW-1:0] rank_q [ENTRIES];
  logic [IW-1:0] rank_d [ENTRIES];

  // rotating line: after ENTRIES rotations every rank is back at its own entry
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      rank_d[k] = rank_q[k];
      if (cmd_i.rotate) begin
        rank_d[k] = rank_q[(k + 1) % ENTRIES];
      end else if (cmd_i.touch) begin
        if (IW'(k) == idx_i) begin
          rank_d[k] = '0;
        end else if (rank_q[k] < old_i) begin
          rank_d[k] = rank_q[k] + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        rank_q[k] <= IW'(k);
      end
    end else begin
      for (int k = 0; k < ENTRIES; k++) begin
        rank_q[k] <= rank_d[k];
      end
    end
  end

  assign head_o = rank_q[0];

endmodule

// ----- rtl/core/sector_cache_lru_controller.sv -----
// access: an accepted request passes through the scan, update and output states, its length
//   set by the single sequential tag scan through the tag ram port
// flush: clean entries are skipped in the flush scan; each dirty entry is read, then output
// not ready while an item is in flight or its result waits for transfer
// reset clears valid and dirty marks and sets entry i to recency rank i; no clearing pass
module sector_cache_lru_controller import sclru_pkg::*; #(
  parameter int unsigned ENTRIES     = ENTRIES_DEF,
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sclru_req_if.sink   req_i,
  sclru_rsp_if.source rsp_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned SB = SECTOR_BITS;
  localparam logic [IW-1:0] LRU_RANK = IW'(ENTRIES - 1);
  localparam logic [IW:0]   CNT_END  = (IW + 1)'(ENTRIES);

  state_e state_q, state_d;
  logic [IW:0]       cnt_q, cnt_d;
  logic              cmp_vld_q;
  logic [IW-1:0]     cmp_idx_q;
  logic              wr_q;
  logic              fl_q;
  logic [SB-1:0]     sec_q;
  logic [ENTRIES-1:0] valid_q, dirty_q;
  logic              hit_found_q, inv_found_q;
  logic [IW-1:0]     hit_idx_q, hit_rank_q, inv_idx_q, inv_rank_q, lru_idx_q;
  logic [SB-1:0]     lru_tag_q;

  logic [IW-1:0]     way_idx_q;
  logic              hit_q, fill_q, wb_q, last_q;
  logic [SB-1:0]     wbsec_q;

  logic              req_xfer, rsp_xfer;
  logic [ENTRIES-1:0] vd, vd_rest;
  logic [IW-1:0]     scan_idx;
  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [SB-1:0]     ram_rdata;
  rank_cmd_t         rank_cmd;
  logic [IW-1:0]     rank_head;
  logic [IW-1:0]     sel_idx, sel_old;
  logic              sel_wb;
  logic              cmp_match;
  logic [IW+WAY_W-1:0]    way_ext;
  logic [SB+SECTOR_W-1:0] wbsec_ext;

  assign req_xfer = req_i.valid & req_i.ready;
  assign rsp_xfer = rsp_o.valid & rsp_o.ready;
  assign vd       = valid_q & dirty_q;
  assign scan_idx = cnt_q[IW-1:0];
  assign vd_rest  = vd & ~(ENTRIES'(1) << scan_idx);
  assign cmp_match = valid_q[cmp_idx_q] && (ram_rdata == sec_q);

  // pick the entry serving the access: hit, else first free, else lru
  always_comb begin
    sel_wb = 1'b0;
    if (hit_found_q) begin
      sel_idx = hit_idx_q;
      sel_old = hit_rank_q;
    end else if (inv_found_q) begin
      sel_idx = inv_idx_q;
      sel_old = inv_rank_q;
    end else begin
      sel_idx = lru_idx_q;
      sel_old = LRU_RANK;
      sel_wb  = dirty_q[lru_idx_q];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          unique case (action_e'(req_i.action)) inside
            ACT_READ, ACT_WRITE: state_d = ST_SCAN;
            ACT_FLUSH: state_d = (vd == '0) ? ST_OUT : ST_FL_SCAN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_END) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: state_d = ST_OUT;
      ST_FL_SCAN: begin
        if (vd[scan_idx]) begin
          state_d = ST_FL_RD;
        end
      end
      ST_FL_RD: state_d = ST_OUT;
      ST_OUT: begin
        if (rsp_xfer) begin
          state_d = (fl_q && !last_q) ? ST_FL_SCAN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req_i.ready     = 1'b0;
    rsp_o.valid     = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = scan_idx;
    rank_cmd.rotate = cmp_vld_q;
    rank_cmd.touch  = 1'b0;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_UPD: begin
        ram_we         = !hit_found_q;
        ram_addr       = sel_idx;
        rank_cmd.touch = 1'b1;
      end
      ST_OUT: rsp_o.valid = 1'b1;
      default: ;
    endcase
  end

  // scan and flush counter
  always_comb begin
    cnt_d = cnt_q;
    unique case (state_q)
      ST_IDLE: cnt_d = '0;
      ST_SCAN: cnt_d = cnt_q + (IW + 1)'(1);
      ST_FL_SCAN: begin
        if (!vd[scan_idx]) begin
          cnt_d = cnt_q + (IW + 1)'(1);
        end
      end
      ST_OUT: begin
        if (rsp_xfer) begin
          cnt_d = cnt_q + (IW + 1)'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      valid_q     <= '0;
      dirty_q     <= '0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
      fl_q        <= 1'b0;
      wr_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= (state_q == ST_SCAN) && (cnt_q != CNT_END);
      if (req_xfer) begin
        hit_found_q <= 1'b0;
        inv_found_q <= 1'b0;
        fl_q        <= (action_e'(req_i.action) == ACT_FLUSH);
        wr_q        <= (action_e'(req_i.action) == ACT_WRITE);
      end
      if (cmp_vld_q) begin
        if (cmp_match && !hit_found_q) begin
          hit_found_q <= 1'b1;
        end
        if (!valid_q[cmp_idx_q] && !inv_found_q) begin
          inv_found_q <= 1'b1;
        end
      end
      if (state_q == ST_UPD) begin
        valid_q[sel_idx] <= 1'b1;
        if (wr_q) begin
          dirty_q[sel_idx] <= 1'b1;
        end else if (!hit_found_q) begin
          dirty_q[sel_idx] <= 1'b0;
        end
      end
      if (state_q == ST_FL_RD) begin
        dirty_q[scan_idx] <= 1'b0;
      end
    end
  end

  // payload and scan records
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_idx;
    if (req_xfer) begin
      sec_q     <= req_i.sector[SB-1:0];
      way_idx_q <= '0;
      hit_q     <= 1'b0;
      fill_q    <= 1'b0;
      wb_q      <= 1'b0;
      wbsec_q   <= '0;
      last_q    <= 1'b1;
    end
    if (cmp_vld_q) begin
      if (cmp_match && !hit_found_q) begin
        hit_idx_q  <= cmp_idx_q;
        hit_rank_q <= rank_head;
      end
      if (!valid_q[cmp_idx_q] && !inv_found_q) begin
        inv_idx_q  <= cmp_idx_q;
        inv_rank_q <= rank_head;
      end
      if (rank_head == LRU_RANK) begin
        lru_idx_q <= cmp_idx_q;
        lru_tag_q <= ram_rdata;
      end
    end
    if (state_q == ST_UPD) begin
      way_idx_q <= sel_idx;
      hit_q     <= hit_found_q;
      fill_q    <= !hit_found_q;
      wb_q      <= sel_wb;
      wbsec_q   <= sel_wb ? lru_tag_q : '0;
      last_q    <= 1'b1;
    end
    if (state_q == ST_FL_RD) begin
      way_idx_q <= scan_idx;
      hit_q     <= 1'b0;
      fill_q    <= 1'b0;
      wb_q      <= 1'b1;
      wbsec_q   <= ram_rdata;
      last_q    <= (vd_rest == '0);
    end
  end

  sclru_ram #(
    .WIDTH (SB),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sec_q),
    .rdata_o (ram_rdata)
  );

  sclru_rank #(
    .ENTRIES (ENTRIES)
  ) u_rank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rank_cmd),
    .idx_i  (sel_idx),
    .old_i  (sel_old),
    .head_o (rank_head)
  );

  assign way_ext   = {{WAY_W{1'b0}}, way_idx_q};
  assign wbsec_ext = {{SECTOR_W{1'b0}}, wbsec_q};

  assign rsp_o.way              = way_ext[WAY_W-1:0];
  assign rsp_o.hit              = hit_q;
  assign rsp_o.fill_needed      = fill_q;
  assign rsp_o.writeback_needed = wb_q;
  assign rsp_o.writeback_sector = wbsec_ext[SECTOR_W-1:0];
  assign rsp_o.last             = last_q;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench import sclru_pkg::*; ();

  localparam int unsigned NUM_ENTRIES  = ENTRIES_DEF;
  localparam int unsigned NUM_SECBITS  = SECTOR_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_AT     = 150;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [SECTOR_W-1:0] SECTOR_MASK = SECTOR_W'((64'd1 << NUM_SECBITS) - 64'd1);

  typedef struct {
    action_e             act;
    logic [SECTOR_W-1:0] sector;
    int unsigned         gap;
    bit                  drain;
  } cache_req_t;

  typedef struct packed {
    logic [WAY_W-1:0]    way;
    logic                hit;
    logic                fill_needed;
    logic                writeback_needed;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } cache_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sclru_req_if req_if ();
  sclru_rsp_if rsp_if ();

  sector_cache_lru_controller #(
    .ENTRIES     (NUM_ENTRIES),
    .SECTOR_BITS (NUM_SECBITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // predicted cache state
  logic [SECTOR_W-1:0] cache_tag   [NUM_ENTRIES];
  logic                cache_valid [NUM_ENTRIES];
  logic                cache_dirty [NUM_ENTRIES];
  logic [WAY_W-1:0]    cache_rank  [NUM_ENTRIES];

  cache_req_t  pending_req_q[$];
  cache_rsp_t  expected_rsp_q[$];
  int unsigned req_accepted;
  int unsigned n_items;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  bit          hold_done;

  cache_req_t  drv_cur;
  bit          drv_loaded;
  int unsigned drv_gap;
  int unsigned mon_gap;
  int unsigned rsp_seen;

  task automatic report_mismatch(input string what, input logic [SECTOR_W-1:0] got,
                                 input logic [SECTOR_W-1:0] want);
    if (err_cnt < 40) $display("mismatch: %s got %0h want %0h", what, got, want);
    err_cnt++;
  endtask

  task automatic make_recent(input int unsigned e);
    logic [WAY_W-1:0] old;
    old = cache_rank[e];
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cache_rank[i] < old) cache_rank[i] = cache_rank[i] + 1'b1;
    end
    cache_rank[e] = '0;
  endtask

  task automatic predict_cache_access(input cache_req_t it);
    cache_rsp_t  r;
    logic [SECTOR_W-1:0] sec;
    int          e;
    int          last_dirty;
    bit          found;
    sec = it.sector & SECTOR_MASK;
    r   = '0;
    e   = 0;
    found = 1'b0;
    case (it.act)
      ACT_READ, ACT_WRITE: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!found && cache_valid[i] && cache_tag[i] == sec) begin
            e = i;
            found = 1'b1;
          end
        end
        if (found) begin
          make_recent(e);
          if (it.act == ACT_WRITE) cache_dirty[e] = 1'b1;
          r.way = WAY_W'(e);
          r.hit = 1'b1;
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!found && !cache_valid[i]) begin
              e = i;
              found = 1'b1;
            end
          end
          // no free entry: evict the least recently used one
          if (!found) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
              if (cache_rank[i] == WAY_W'(NUM_ENTRIES - 1)) e = i;
            end
            if (cache_dirty[e]) begin
              r.writeback_needed = 1'b1;
              r.writeback_sector = cache_tag[e];
            end
          end
          cache_tag[e]   = sec;
          cache_valid[e] = 1'b1;
          cache_dirty[e] = (it.act == ACT_WRITE);
          make_recent(e);
          r.way         = WAY_W'(e);
          r.fill_needed = 1'b1;
        end
        r.last = 1'b1;
        expected_rsp_q.push_back(r);
      end
      ACT_FLUSH: begin
        last_dirty = -1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (cache_valid[i] && cache_dirty[i]) last_dirty = i;
        end
        if (last_dirty < 0) begin
          r.last = 1'b1;
          expected_rsp_q.push_back(r);
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (cache_valid[i] && cache_dirty[i]) begin
              r = '0;
              r.way              = WAY_W'(i);
              r.writeback_needed = 1'b1;
              r.writeback_sector = cache_tag[i];
              r.last             = (i == last_dirty);
              cache_dirty[i]     = 1'b0;
              expected_rsp_q.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_req(input action_e act, input logic [SECTOR_W-1:0] sector,
                         input bit drain);
    cache_req_t it;
    it.act    = act;
    it.sector = sector;
    it.drain  = drain;
    // back-to-back stretches with no sender gaps
    if ((n_items >= 40 && n_items < 90) || (n_items >= 200 && n_items < 240)) it.gap = 0;
    else it.gap = $urandom_range(0, 9);
    pending_req_q.push_back(it);
    n_items++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic nxt_valid;
    if (!rst_ni) begin
      req_if.valid  <= 1'b0;
      req_if.action <= ACT_READ;
      req_if.sector <= '0;
      req_accepted  <= 0;
      drv_loaded = 1'b0;
      drv_gap    = 0;
    end else begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predict_cache_access(drv_cur);
        req_accepted <= req_accepted + 1;
        nxt_valid  = 1'b0;
        drv_loaded = 1'b0;
      end
      if (!nxt_valid) begin
        if (!drv_loaded && pending_req_q.size() != 0) begin
          drv_cur    = pending_req_q.pop_front();
          drv_loaded = 1'b1;
          drv_gap    = drv_cur.gap;
        end
        if (drv_loaded) begin
          if (drv_gap > 0) drv_gap--;
          else if (!drv_cur.drain || (expected_rsp_q.size() == 0 && !rsp_if.valid))
            nxt_valid = 1'b1;
        end
      end
      req_if.valid  <= nxt_valid;
      req_if.action <= drv_cur.act;
      req_if.sector <= drv_cur.sector;
    end
  end

  // long receiver hold-off so the block backs up its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    cache_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mon_gap  = 0;
      rsp_seen = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with none expected, way", SECTOR_W'(rsp_if.way), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_if.way !== want.way)
            report_mismatch("way", SECTOR_W'(rsp_if.way), SECTOR_W'(want.way));
          if (rsp_if.hit !== want.hit)
            report_mismatch("hit", SECTOR_W'(rsp_if.hit), SECTOR_W'(want.hit));
          if (rsp_if.fill_needed !== want.fill_needed)
            report_mismatch("fill_needed", SECTOR_W'(rsp_if.fill_needed),
                            SECTOR_W'(want.fill_needed));
          if (rsp_if.writeback_needed !== want.writeback_needed)
            report_mismatch("writeback_needed", SECTOR_W'(rsp_if.writeback_needed),
                            SECTOR_W'(want.writeback_needed));
          if (rsp_if.writeback_sector !== want.writeback_sector)
            report_mismatch("writeback_sector", rsp_if.writeback_sector,
                            want.writeback_sector);
          if (rsp_if.last !== want.last)
            report_mismatch("last", SECTOR_W'(rsp_if.last), SECTOR_W'(want.last));
        end
        rsp_seen++;
        mon_gap = ((rsp_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [SECTOR_W-1:0] pool [POOL_SIZE];
    int unsigned counted;
    int unsigned r;
    action_e     act;
    logic [SECTOR_W-1:0] sec;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = ACT_READ;
    req_if.sector    = '0;
    rsp_if.ready     = 1'b0;
    cycle_cnt        = 0;
    err_cnt          = 0;
    n_items          = 0;

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cache_tag[i]   = '0;
      cache_valid[i] = 1'b0;
      cache_dirty[i] = 1'b0;
      cache_rank[i]  = WAY_W'(i);
    end

    // directed part
    add_req(ACT_FLUSH, 32'h0000_0000, 1'b0);  // flush with nothing dirty
    add_req(ACT_READ,  32'h0000_0000, 1'b0);
    add_req(ACT_READ,  32'h0000_0000, 1'b0);  // read hit
    add_req(ACT_WRITE, 32'hFFFF_FFFF, 1'b0);  // write miss
    add_req(ACT_WRITE, 32'hFFFF_FFFF, 1'b0);  // write hit
    add_req(ACT_WRITE, 32'h0000_0000, 1'b0);  // dirty a clean entry
    add_req(ACT_NONE,  32'h1234_5678, 1'b0);  // ignored code
    add_req(ACT_READ,  32'hAAAA_AAAA, 1'b0);
    add_req(ACT_WRITE, 32'h5555_5555, 1'b0);
    add_req(ACT_FLUSH, 32'hFFFF_FFFF, 1'b0);  // several dirty entries
    add_req(ACT_FLUSH, 32'h0000_0000, 1'b0);
    add_req(ACT_READ,  32'h0000_0000, 1'b0);
    add_req(ACT_WRITE, 32'h8000_0000, 1'b0);
    add_req(ACT_READ,  32'h0000_0001, 1'b0);
    add_req(ACT_READ,  32'h5555_5555, 1'b0);
    add_req(ACT_WRITE, 32'h7FFF_FFFF, 1'b1);  // sender waits for the block to drain
    add_req(ACT_FLUSH, 32'h0000_0000, 1'b0);

    // random part: a sector pool somewhat larger than the cache gives hits,
    // then evictions of dirty and clean lru victims
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom();
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_req(ACT_NONE, $urandom(), 1'b0);
      end else begin
        if (r < 9) act = ACT_FLUSH;
        else act = ($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ;
        if ($urandom_range(0, 99) < 85) sec = pool[$urandom_range(0, POOL_SIZE - 1)];
        else sec = $urandom();
        add_req(act, sec, counted == DRAIN_AT);
        counted++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_accepted != n_items) @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_ENTRIES + 10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sector_cache_lru_controller.f -----
rtl/core/sclru_pkg.sv
rtl/core/sclru_if.sv
rtl/core/sclru_ram.sv
rtl/core/sclru_rank.sv
rtl/core/sector_cache_lru_controller.sv
dv/testbench.sv
